### hdl/srt_pkg.sv
// shared constants, types and microcode table of the radix-2 srt divider
package srt_pkg;

  localparam int WIDTH = 16;
  localparam int DW    = 2 * WIDTH;
  localparam int RW    = WIDTH + 2;
  localparam int CNT_W = $clog2(WIDTH);
  localparam int UA_W  = 3;
  localparam int ST_W  = 2;

  typedef logic [UA_W-1:0]  uaddr_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [2:0]       op_t;
  typedef logic [1:0]       wt_t;
  typedef logic [1:0]       cond_t;
  typedef logic [ST_W-1:0]  status_t;

  localparam cnt_t CNT_INIT = CNT_W'(WIDTH - 1);

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_DIV0 = 2'd1;
  localparam status_t ST_OVF  = 2'd2;

  localparam op_t OP_NOP   = 3'd0;
  localparam op_t OP_LOAD  = 3'd1;
  localparam op_t OP_CHECK = 3'd2;
  localparam op_t OP_ITER  = 3'd3;
  localparam op_t OP_FIX   = 3'd4;
  localparam op_t OP_EMIT  = 3'd5;

  localparam wt_t WT_NONE = 2'd0;
  localparam wt_t WT_IN   = 2'd1;
  localparam wt_t WT_OUT  = 2'd2;

  localparam cond_t COND_NEXT = 2'd0;
  localparam cond_t COND_JUMP = 2'd1;
  localparam cond_t COND_ERR  = 2'd2;
  localparam cond_t COND_LOOP = 2'd3;

  localparam uaddr_t U_IDLE  = 3'd0;
  localparam uaddr_t U_CHECK = 3'd1;
  localparam uaddr_t U_ITER  = 3'd2;
  localparam uaddr_t U_FIX   = 3'd3;
  localparam uaddr_t U_EMIT  = 3'd4;

  typedef struct packed {
    wt_t    wt;
    op_t    op;
    cond_t  cond;
    logic   cnt_init;
    uaddr_t target;
  } ucw_t;

  function automatic ucw_t ucode_rom(input uaddr_t addr);
    ucw_t w;
    case (addr)
      U_IDLE:  w = '{wt: WT_IN,   op: OP_LOAD,  cond: COND_NEXT, cnt_init: 1'b0, target: U_IDLE};
      U_CHECK: w = '{wt: WT_NONE, op: OP_CHECK, cond: COND_ERR,  cnt_init: 1'b1, target: U_EMIT};
      U_ITER:  w = '{wt: WT_NONE, op: OP_ITER,  cond: COND_LOOP, cnt_init: 1'b0, target: U_ITER};
      U_FIX:   w = '{wt: WT_NONE, op: OP_FIX,   cond: COND_NEXT, cnt_init: 1'b0, target: U_IDLE};
      U_EMIT:  w = '{wt: WT_OUT,  op: OP_EMIT,  cond: COND_JUMP, cnt_init: 1'b0, target: U_IDLE};
      default: w = '{wt: WT_NONE, op: OP_NOP,   cond: COND_JUMP, cnt_init: 1'b0, target: U_IDLE};
    endcase
    return w;
  endfunction

endpackage

### hdl/srt_if.sv
// valid/ready channel interfaces for the divider operand and result words
interface srt_in_if import srt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DW-1:0]       dividend;
  logic [WIDTH-1:0]    divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface srt_out_if import srt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [WIDTH-1:0]    quotient;
  logic [WIDTH-1:0]    remainder;
  logic [ST_W-1:0]     status;

  modport source (output valid, output quotient, output remainder, output status, input ready);
  modport sink   (input valid, input quotient, input remainder, input status, output ready);
endinterface

### hdl/srt_useq.sv
// microcode sequencer: step counter, iteration counter and jump logic
module srt_useq import srt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic out_free,
  input  logic err,
  output logic in_ready,
  output op_t  op
);

  uaddr_t upc_r, upc_nxt, upc_inc;
  cnt_t   cnt_r, cnt_nxt;
  ucw_t   ucw;
  logic   hold;

  assign ucw      = ucode_rom(upc_r);
  assign upc_inc  = upc_r + UA_W'(1);
  assign hold     = (ucw.wt == WT_IN && !in_valid) || (ucw.wt == WT_OUT && !out_free);
  assign in_ready = (ucw.wt == WT_IN);
  assign op       = hold ? OP_NOP : ucw.op;

  always_comb begin
    case (ucw.cond)
      COND_NEXT: upc_nxt = upc_inc;
      COND_JUMP: upc_nxt = ucw.target;
      COND_ERR:  upc_nxt = err ? ucw.target : upc_inc;
      COND_LOOP: upc_nxt = (cnt_r != '0) ? ucw.target : upc_inc;
      default:   upc_nxt = U_IDLE;
    endcase
    if (hold) begin
      upc_nxt = upc_r;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (!hold) begin
      if (ucw.cnt_init) begin
        cnt_nxt = CNT_INIT;
      end else if (ucw.cond == COND_LOOP && cnt_r != '0) begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= U_IDLE;
      cnt_r <= '0;
    end else begin
      upc_r <= upc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_loop_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == U_ITER && upc_nxt == U_FIX) |-> (cnt_r == '0))
    else $error("iteration loop left early");

  a_check_arms_count: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == U_CHECK && !err) |=> (upc_r == U_ITER && cnt_r == CNT_INIT))
    else $error("iteration count not armed");

endmodule

### hdl/srt_dpath.sv
// divider datapath: partial remainder, quotient shifter, add/subtract unit, result word
module srt_dpath import srt_pkg::*; (
  input  logic             clk,
  input  op_t              op,
  input  logic [DW-1:0]    in_dividend,
  input  logic [WIDTH-1:0] in_divisor,
  output logic             err,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder,
  output status_t          status
);

  logic [RW-1:0]    rem_r, rem_nxt, sh, bx;
  logic [WIDTH-1:0] q_r, q_nxt, b_r, b_nxt;
  status_t          st_r, st_nxt;
  logic [WIDTH-1:0] quo_r, quo_nxt, rmd_r, rmd_nxt;
  status_t          sts_r, sts_nxt;
  logic             b_zero, hi_ge;

  assign bx     = {2'b00, b_r};
  assign sh     = {rem_r[RW-2:0], q_r[WIDTH-1]};
  assign b_zero = (b_r == '0);
  assign hi_ge  = (rem_r[WIDTH-1:0] >= b_r);
  assign err    = b_zero || hi_ge;

  always_comb begin
    rem_nxt = rem_r;
    q_nxt   = q_r;
    b_nxt   = b_r;
    st_nxt  = st_r;
    quo_nxt = quo_r;
    rmd_nxt = rmd_r;
    sts_nxt = sts_r;
    case (op)
      OP_LOAD: begin
        rem_nxt = {2'b00, in_dividend[DW-1:WIDTH]};
        q_nxt   = in_dividend[WIDTH-1:0];
        b_nxt   = in_divisor;
      end
      OP_CHECK: begin
        if (b_zero) begin
          st_nxt = ST_DIV0;
        end else if (hi_ge) begin
          st_nxt = ST_OVF;
        end else begin
          st_nxt = ST_OK;
        end
      end
      OP_ITER: begin
        rem_nxt = rem_r[RW-1] ? (sh + bx) : (sh - bx);
        q_nxt   = {q_r[WIDTH-2:0], ~rem_nxt[RW-1]};
      end
      OP_FIX: begin
        if (rem_r[RW-1]) begin
          rem_nxt = rem_r + bx;
        end
      end
      OP_EMIT: begin
        quo_nxt = (st_r == ST_OK) ? q_r : '0;
        rmd_nxt = (st_r == ST_OK) ? rem_r[WIDTH-1:0] : '0;
        sts_nxt = st_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    b_r   <= b_nxt;
    st_r  <= st_nxt;
    quo_r <= quo_nxt;
    rmd_r <= rmd_nxt;
    sts_r <= sts_nxt;
  end

  assign quotient  = quo_r;
  assign remainder = rmd_r;
  assign status    = sts_r;

  a_rem_corrected: assert property (@(posedge clk)
    (op == OP_EMIT && st_r == ST_OK) |-> !rem_r[RW-1])
    else $error("negative remainder at result");

  a_rem_bound: assert property (@(posedge clk)
    (op == OP_EMIT && st_r == ST_OK) |-> (rem_r[WIDTH-1:0] < b_r))
    else $error("remainder not below divisor");

endmodule

### hdl/srt_radix2_divider.sv
// top level of the radix-2 srt divider
// Divides a 2*WIDTH-bit fractional dividend by a WIDTH-bit divisor, one word
// at a time. An accepted word is loaded, checked for a zero divisor or
// overflow, then worked through the quotient bits, the remainder correction
// and the write of the result register; a zero divisor or overflow result
// goes from the check straight to the result write. The single add/subtract
// unit retires one quotient bit per cycle under the microcode program. The
// result register lets the next word be taken and worked on while a finished
// result is still waiting.
module srt_radix2_divider import srt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  srt_in_if.sink    in_word,
  srt_out_if.source out_word
);

  op_t  op;
  logic err;
  logic out_free;
  logic out_valid_r, out_valid_nxt;

  assign out_free = !out_valid_r || out_word.ready;

  srt_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_word.valid),
    .out_free (out_free),
    .err      (err),
    .in_ready (in_word.ready),
    .op       (op)
  );

  srt_dpath u_dpath (
    .clk         (clk),
    .op          (op),
    .in_dividend (in_word.dividend),
    .in_divisor  (in_word.divisor),
    .err         (err),
    .quotient    (out_word.quotient),
    .remainder   (out_word.remainder),
    .status      (out_word.status)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (op == OP_EMIT) begin
      out_valid_nxt = 1'b1;
    end else if (out_word.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_word.valid = out_valid_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_word.valid && in_word.ready) |=> !in_word.ready)
    else $error("word taken while busy");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_EMIT) |=> out_word.valid)
    else $error("result not presented");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_word.valid && out_word.status != ST_OK) |->
      (out_word.quotient == '0 && out_word.remainder == '0))
    else $error("error result carries data");

endmodule
